// File: rtl/fplm_pkg.sv
// Shared types and constants for the FIFO lot matcher.
package fplm_pkg;

  localparam int unsigned QTY_W   = 16;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned PNL_W   = 49;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned TRADE_W = 32;
  localparam int unsigned POS_W   = 23;
  localparam int unsigned CLOSE_W = 7;
  localparam int unsigned DIFF_W  = PRICE_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + QTY_W + 1;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } lot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_APPEND,
    ST_FINISH
  } state_e;

endpackage

// File: rtl/fplm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fplm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fifo_lot_pnl_matcher_core.sv
// FIFO lot matcher: lot queue in RAM, realized P&L and trade totals.
// Flow: an ignored transaction goes from accept straight to ST_FINISH, where the result register loads;
// a fill goes through ST_CHECK, then ST_READ for each lot it closes or reduces, then ST_APPEND and ST_FINISH.
// Each such lot is read from the lot memory in ST_CHECK and updated in ST_READ.
// One transaction at a time; the next is accepted the cycle after the result is loaded at the earliest,
// and ST_FINISH waits while the output is stalled.
// Reset (async, active low) clears pointers, totals and handshake state; lot RAM is not cleared.
module fifo_lot_pnl_matcher_core #(
  parameter int unsigned MAX_LOTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 is_filled_i,
  input  logic                                 is_sell_i,
  input  logic [fplm_pkg::QTY_W-1:0]           fill_qty_i,
  input  logic [fplm_pkg::PRICE_W-1:0]         fill_price_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [fplm_pkg::PNL_W-1:0]    fill_pnl_o,
  output logic [fplm_pkg::CLOSE_W-1:0]         lots_closed_o,
  output logic signed [fplm_pkg::TOTAL_W-1:0]  total_pnl_o,
  output logic [fplm_pkg::TRADE_W-1:0]         total_trades_o,
  output logic signed [fplm_pkg::POS_W-1:0]    open_position_o,
  output logic                                 lot_dropped_o
);

  localparam int unsigned IW  = $clog2(MAX_LOTS);
  localparam int unsigned CW  = $clog2(MAX_LOTS + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned PW  = fplm_pkg::QTY_W + CW;
  localparam int unsigned LW  = $bits(fplm_pkg::lot_t);
  localparam int unsigned XW  = fplm_pkg::TOTAL_W - fplm_pkg::PROD_W;

  fplm_pkg::state_e state_q, state_d;

  logic [IW-1:0]                     head_q, head_d;
  logic [CW-1:0]                     count_q, count_d;
  logic                              short_q, short_d;
  logic [fplm_pkg::TOTAL_W-1:0]      total_q, total_d;
  logic [fplm_pkg::TRADE_W-1:0]      trades_q, trades_d;
  logic [PW-1:0]                     pos_q, pos_d;
  logic                              prod_valid_q, prod_valid_d;
  logic                              out_valid_q, out_valid_d;

  logic                              sell_q;
  logic [fplm_pkg::PRICE_W-1:0]      price_q;
  logic [fplm_pkg::QTY_W-1:0]        rem_q;
  logic [CW-1:0]                     closed_q;
  logic [fplm_pkg::PNL_W-1:0]        fpnl_q;
  logic                              dropped_q;
  logic signed [fplm_pkg::PROD_W-1:0] prod_q;

  logic [fplm_pkg::PNL_W-1:0]        out_fpnl_q;
  logic [fplm_pkg::CLOSE_W-1:0]      out_closed_q;
  logic [fplm_pkg::TOTAL_W-1:0]      out_total_q;
  logic [fplm_pkg::TRADE_W-1:0]      out_trades_q;
  logic [fplm_pkg::POS_W-1:0]        out_pos_q;
  logic                              out_dropped_q;

  logic                              in_acc;
  logic                              out_free;
  logic                              match;
  logic                              full;
  logic                              load_out;
  logic [SW-1:0]                     tail_sum;
  logic [IW-1:0]                     tail;
  logic [IW-1:0]                     head_inc;

  fplm_pkg::lot_t                    rd_lot;
  fplm_pkg::lot_t                    wr_lot;
  logic [LW-1:0]                     rdata;
  logic                              mem_we, mem_re;
  logic [IW-1:0]                     mem_waddr;

  logic [fplm_pkg::QTY_W-1:0]        take;
  logic                              partial;
  logic signed [fplm_pkg::DIFF_W-1:0] diff;
  logic signed [fplm_pkg::QTY_W:0]   take_s;
  logic signed [fplm_pkg::PROD_W-1:0] prod;
  logic                              do_append;

  logic [CW+fplm_pkg::CLOSE_W-1:0]   closed_ext;
  logic [PW+fplm_pkg::POS_W-1:0]     pos_ext;
  logic [PW+fplm_pkg::POS_W-1:0]     pos_signed;

  assign in_stall_o = (state_q != fplm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign match      = (rem_q != '0) && (count_q != '0) && (short_q != sell_q);
  assign full       = (count_q == CW'(MAX_LOTS));
  assign tail_sum   = SW'(head_q) + SW'(count_q);
  assign tail       = (tail_sum >= SW'(MAX_LOTS)) ? IW'(tail_sum - SW'(MAX_LOTS))
                                                  : IW'(tail_sum);
  assign head_inc   = (head_q == IW'(MAX_LOTS - 1)) ? '0 : head_q + IW'(1);

  assign rd_lot  = fplm_pkg::lot_t'(rdata);
  assign take    = (rd_lot.qty < rem_q) ? rd_lot.qty : rem_q;
  assign partial = (take != rd_lot.qty);
  assign diff    = short_q ? (signed'({1'b0, rd_lot.price}) - signed'({1'b0, price_q}))
                           : (signed'({1'b0, price_q}) - signed'({1'b0, rd_lot.price}));
  assign take_s  = signed'({1'b0, take});
  assign prod    = diff * take_s;
  assign do_append = (state_q == fplm_pkg::ST_APPEND) && (rem_q != '0) && !full;
  assign load_out  = (state_q == fplm_pkg::ST_FINISH) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fplm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (is_filled_i && fill_qty_i != '0) ? fplm_pkg::ST_CHECK
                                                      : fplm_pkg::ST_FINISH;
        end
      end
      fplm_pkg::ST_CHECK:  state_d = match ? fplm_pkg::ST_READ : fplm_pkg::ST_APPEND;
      fplm_pkg::ST_READ:   state_d = fplm_pkg::ST_CHECK;
      fplm_pkg::ST_APPEND: state_d = fplm_pkg::ST_FINISH;
      fplm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = fplm_pkg::ST_IDLE;
        end
      end
      default: state_d = fplm_pkg::ST_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    mem_re    = (state_q == fplm_pkg::ST_CHECK) && match;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    wr_lot    = rd_lot;
    unique case (state_q)
      fplm_pkg::ST_READ: begin
        mem_we     = partial;
        mem_waddr  = head_q;
        wr_lot.qty = rd_lot.qty - take;
      end
      fplm_pkg::ST_APPEND: begin
        mem_we       = do_append;
        mem_waddr    = tail;
        wr_lot.qty   = rem_q;
        wr_lot.price = price_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // queue and totals
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    short_d      = short_q;
    total_d      = total_q;
    trades_d     = trades_q;
    pos_d        = pos_q;
    prod_valid_d = (state_q == fplm_pkg::ST_READ);
    out_valid_d  = out_valid_q && out_stall_i;
    if (prod_valid_q) begin
      total_d = total_q + {{XW{prod_q[fplm_pkg::PROD_W-1]}}, prod_q};
    end
    if (state_q == fplm_pkg::ST_READ) begin
      pos_d = pos_q - PW'(take);
      if (trades_q != '1) begin
        trades_d = trades_q + (fplm_pkg::TRADE_W)'(1);
      end
      if (!partial) begin
        head_d  = head_inc;
        count_d = count_q - CW'(1);
      end
    end
    if (do_append) begin
      if (count_q == '0) begin
        short_d = sell_q;
      end
      count_d = count_q + CW'(1);
      pos_d   = pos_q + PW'(rem_q);
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fplm_pkg::ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      short_q      <= 1'b0;
      total_q      <= '0;
      trades_q     <= '0;
      pos_q        <= '0;
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      short_q      <= short_d;
      total_q      <= total_d;
      trades_q     <= trades_d;
      pos_q        <= pos_d;
      prod_valid_q <= prod_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign closed_ext = (CW + fplm_pkg::CLOSE_W)'(closed_q);
  assign pos_ext    = (PW + fplm_pkg::POS_W)'(pos_q);
  assign pos_signed = short_q ? (~pos_ext + (PW + fplm_pkg::POS_W)'(1)) : pos_ext;

  // per-transaction working registers and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sell_q    <= is_sell_i;
      price_q   <= fill_price_i;
      rem_q     <= fill_qty_i;
      closed_q  <= '0;
      fpnl_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (prod_valid_q) begin
        fpnl_q <= fpnl_q + prod_q[fplm_pkg::PNL_W-1:0];
      end
      if (state_q == fplm_pkg::ST_READ) begin
        rem_q    <= rem_q - take;
        closed_q <= closed_q + CW'(1);
        prod_q   <= prod;
      end
      if ((state_q == fplm_pkg::ST_APPEND) && (rem_q != '0) && full) begin
        dropped_q <= 1'b1;
      end
    end
    if (load_out) begin
      out_fpnl_q    <= fpnl_q;
      out_closed_q  <= closed_ext[fplm_pkg::CLOSE_W-1:0];
      out_total_q   <= total_q;
      out_trades_q  <= trades_q;
      out_pos_q     <= pos_signed[fplm_pkg::POS_W-1:0];
      out_dropped_q <= dropped_q;
    end
  end

  fplm_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_LOTS)
  ) u_lot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_lot),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign fill_pnl_o      = signed'(out_fpnl_q);
  assign lots_closed_o   = out_closed_q;
  assign total_pnl_o     = signed'(out_total_q);
  assign total_trades_o  = out_trades_q;
  assign open_position_o = signed'(out_pos_q);
  assign lot_dropped_o   = out_dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LOTS))
    else $error("lot count above capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fplm_pkg::ST_READ) |-> (count_q != '0))
    else $error("lot read from empty queue");

  a_prod_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_valid_q |-> (state_q == fplm_pkg::ST_CHECK))
    else $error("product pending outside check state");

  a_empty_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (pos_q == '0))
    else $error("position nonzero with empty queue");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fplm_pkg::ST_READ) |=> !out_valid_q || $past(out_valid_q))
    else $error("result loaded during lot update");

endmodule

// File: bench/tb.sv
// Testbench for fifo_lot_pnl_matcher_core: directed and random fills checked against a lot-queue predictor.
module tb;

  localparam int unsigned QTY_W        = fplm_pkg::QTY_W;
  localparam int unsigned PRICE_W      = fplm_pkg::PRICE_W;
  localparam int unsigned PNL_W        = fplm_pkg::PNL_W;
  localparam int unsigned TOTAL_W      = fplm_pkg::TOTAL_W;
  localparam int unsigned TRADE_W      = fplm_pkg::TRADE_W;
  localparam int unsigned POS_W        = fplm_pkg::POS_W;
  localparam int unsigned CLOSE_W      = fplm_pkg::CLOSE_W;
  localparam int unsigned MAX_LOTS     = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 4 * MAX_LOTS;
  localparam logic        BUY          = 1'b0;
  localparam logic        SELL         = 1'b1;

  typedef struct {
    logic signed [PNL_W-1:0]   fill_pnl;
    logic [CLOSE_W-1:0]        lots_closed;
    logic signed [TOTAL_W-1:0] total_pnl;
    logic [TRADE_W-1:0]        total_trades;
    logic signed [POS_W-1:0]   open_position;
    logic                      lot_dropped;
  } fill_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      is_filled_i = 1'b0;
  logic                      is_sell_i = 1'b0;
  logic [QTY_W-1:0]          fill_qty_i = '0;
  logic [PRICE_W-1:0]        fill_price_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [PNL_W-1:0]   fill_pnl_o;
  logic [CLOSE_W-1:0]        lots_closed_o;
  logic signed [TOTAL_W-1:0] total_pnl_o;
  logic [TRADE_W-1:0]        total_trades_o;
  logic signed [POS_W-1:0]   open_position_o;
  logic                      lot_dropped_o;

  // predictor copy of the lot book
  logic [QTY_W-1:0]   book_qty [MAX_LOTS];
  logic [PRICE_W-1:0] book_price [MAX_LOTS];
  int unsigned        book_head = 0;
  int unsigned        book_count = 0;
  logic               book_short = 1'b0;
  logic [TOTAL_W-1:0] book_pnl = '0;
  logic [TRADE_W-1:0] book_trades = '0;

  fill_result_t expected_fills[$];
  fill_result_t next_fill;
  logic [PRICE_W-1:0] mark = 32'd1000000;
  int unsigned send_idle_pct = 38;
  int unsigned recv_stall_pct = 51;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  fifo_lot_pnl_matcher_core #(
    .MAX_LOTS(MAX_LOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .is_filled_i    (is_filled_i),
    .is_sell_i      (is_sell_i),
    .fill_qty_i     (fill_qty_i),
    .fill_price_i   (fill_price_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fill_pnl_o     (fill_pnl_o),
    .lots_closed_o  (lots_closed_o),
    .total_pnl_o    (total_pnl_o),
    .total_trades_o (total_trades_o),
    .open_position_o(open_position_o),
    .lot_dropped_o  (lot_dropped_o)
  );

  always begin
    #2;
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
  end

  function automatic int unsigned open_qty();
    int unsigned sum;
    sum = 0;
    for (int unsigned i = 0; i < book_count; i++) sum += book_qty[(book_head + i) % MAX_LOTS];
    return sum;
  endfunction

  function automatic fill_result_t match_fill(logic filled, logic sell, logic [QTY_W-1:0] qty,
                                              logic [PRICE_W-1:0] price);
    fill_result_t r;
    int unsigned  remaining;
    int unsigned  take;
    int unsigned  slot;
    int unsigned  closed;
    longint       realized;
    longint       diff;
    longint       net;
    logic         dropped;
    realized  = 0;
    closed    = 0;
    dropped   = 1'b0;
    remaining = qty;
    if (filled && qty != 0) begin
      while (remaining != 0 && book_count != 0 && book_short != sell) begin
        slot = book_head;
        take = book_qty[slot] < remaining ? book_qty[slot] : remaining;
        diff = $signed({32'd0, price}) - $signed({32'd0, book_price[slot]});
        if (book_short) diff = -diff;
        realized += diff * longint'(take);
        closed++;
        if (book_trades != '1) book_trades++;
        if (take == book_qty[slot]) begin
          book_head = (book_head + 1) % MAX_LOTS;
          book_count--;
        end else begin
          book_qty[slot] = book_qty[slot] - QTY_W'(take);
        end
        remaining -= take;
      end
      if (remaining != 0) begin
        if (book_count >= MAX_LOTS) begin
          dropped = 1'b1;
        end else begin
          if (book_count == 0) book_short = sell;
          slot = (book_head + book_count) % MAX_LOTS;
          book_qty[slot]   = QTY_W'(remaining);
          book_price[slot] = price;
          book_count++;
        end
      end
      book_pnl += realized;
    end
    net = open_qty();
    if (book_short) net = -net;
    r.fill_pnl      = realized[PNL_W-1:0];
    r.lots_closed   = closed[CLOSE_W-1:0];
    r.total_pnl     = book_pnl;
    r.total_trades  = book_trades;
    r.open_position = net[POS_W-1:0];
    r.lot_dropped   = dropped;
    return r;
  endfunction

  task automatic send_fill(logic filled, logic sell, logic [QTY_W-1:0] qty,
                           logic [PRICE_W-1:0] price);
    fill_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    is_filled_i  <= filled;
    is_sell_i    <= sell;
    fill_qty_i   <= qty;
    fill_price_i <= price;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted      = match_fill(filled, sell, qty, price);
    expected_fills = {expected_fills, predicted};
    sent_count++;
  endtask

  task automatic report_mismatch(string msg);
    $display("tb: mismatch on result %0d: %s", checked_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_fills.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        next_fill = expected_fills.pop_front();
        check_field("fill_pnl", fill_pnl_o, next_fill.fill_pnl);
        check_field("lots_closed", lots_closed_o, next_fill.lots_closed);
        check_field("total_pnl", total_pnl_o, next_fill.total_pnl);
        check_field("total_trades", total_trades_o, next_fill.total_trades);
        check_field("open_position", open_position_o, next_fill.open_position);
        check_field("lot_dropped", lot_dropped_o, next_fill.lot_dropped);
      end
      checked_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_fills.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_edge_fills;
    send_fill(1'b0, BUY, 16'd100, 32'd1000);
    send_fill(1'b1, SELL, 16'd0, 32'd1000);
    send_fill(1'b1, BUY, 16'd10, 32'd1000);
    send_fill(1'b1, BUY, 16'hFFFF, 32'hFFFF_FFFF);
    send_fill(1'b1, SELL, 16'd4, 32'd1200);
    send_fill(1'b1, SELL, 16'd6, 32'd900);
    send_fill(1'b1, SELL, 16'hFFFF, 32'h0000_0000);
    send_fill(1'b1, SELL, 16'd3, 32'd500);
    send_fill(1'b1, SELL, 16'd7, 32'hFFFF_FFFF);
    send_fill(1'b1, BUY, 16'd1, 32'h0000_0000);
    send_fill(1'b0, SELL, 16'hFFFF, 32'hFFFF_FFFF);
    // closes both short lots and flips long
    send_fill(1'b1, BUY, 16'd20, 32'd600);
    send_fill(1'b1, SELL, 16'd11, 32'd600);
    send_fill(1'b1, BUY, 16'h8000, 32'h8000_0000);
    send_fill(1'b1, BUY, 16'h7FFF, 32'h7FFF_FFFF);
    send_fill(1'b1, SELL, 16'hFFFF, 32'h5555_5555);
    send_fill(1'b1, SELL, 16'h5555, 32'hAAAA_AAAA);
    send_fill(1'b1, BUY, 16'hAAAA, 32'h5555_5555);
    send_fill(1'b1, SELL, 16'h5555, 32'h0000_0001);
  endtask

  // flatten, fill every slot, overflow, then sweep the whole queue with one fill
  task automatic test_queue_full;
    int unsigned left;
    logic        sell;
    while (book_count != 0) begin
      left = open_qty();
      send_fill(1'b1, ~book_short, left > 65535 ? 16'hFFFF : QTY_W'(left), mark);
    end
    sell = 1'($urandom);
    for (int unsigned i = 0; i < MAX_LOTS + 3; i++) begin
      send_fill(1'b1, sell, QTY_W'($urandom_range(1, 1000)), mark + $urandom_range(0, 5000));
    end
    send_fill(1'b1, ~sell, 16'hFFFF, mark);
  endtask

  task automatic test_random_fills(int unsigned n);
    int unsigned        done;
    int unsigned        roll;
    int unsigned        depth;
    longint             span;
    logic               sell;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] px;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_fill(1'b0, 1'($urandom), QTY_W'($urandom), $urandom);
      end else if (roll < 6) begin
        send_fill(1'b1, 1'($urandom), '0, $urandom);
      end else begin
        roll = $urandom_range(0, 99);
        if (book_count == 0 || roll >= 85) sell = 1'($urandom);
        else if (roll < 45) sell = ~book_short;
        else sell = book_short;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          qty = QTY_W'($urandom_range(1, 200));
        end else if (roll < 65 && book_count != 0) begin
          qty = book_qty[book_head];
        end else if (roll < 80 && book_count != 0) begin
          depth = $urandom_range(1, book_count < 8 ? book_count : 8);
          span = 0;
          for (int unsigned k = 0; k < depth; k++) span += book_qty[(book_head + k) % MAX_LOTS];
          span = span + $urandom_range(0, 2) - 1;
          if (span < 1) span = 1;
          qty = span > 65535 ? 16'hFFFF : QTY_W'(span);
        end else if (roll < 95) begin
          qty = QTY_W'($urandom_range(1, 65535));
        end else begin
          qty = 16'hFFFF;
        end
        mark = mark + $urandom_range(0, 200) - 100;
        roll = $urandom_range(0, 99);
        if (roll < 85) px = mark + $urandom_range(0, 50);
        else if (roll < 95) px = $urandom;
        else px = roll[0] ? '1 : '0;
        send_fill(1'b1, sell, qty, px);
        done++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_fills();
    test_queue_full();
    test_random_fills(200);

    send_idle_pct  = 51;
    recv_stall_pct = 38;
    test_random_fills(200);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_queue_full();
    test_random_fills(200);

    in_valid_i <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d transactions sent, %0d results checked, %0d mismatches", sent_count,
             checked_count, mismatches);
    $display("tb: ignored fills, partial and whole closes, side flips, drops on a full queue");
    if (mismatches == 0 && expected_fills.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fplm_pkg.sv
rtl/fplm_ram.sv
rtl/fifo_lot_pnl_matcher_core.sv
bench/tb.sv
